>>> rtl/core/mau_pkg.sv
// ----------------------------------------------------------------------------
// mau_pkg
// Shared types and constants of the modular arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

    localparam int RES_W = 31;

    typedef enum logic [3:0] {
        CMD_REDUCE = 4'd0,
        CMD_ADD    = 4'd1,
        CMD_SUB    = 4'd2,
        CMD_MUL    = 4'd3,
        CMD_DIV    = 4'd4,
        CMD_POW    = 4'd5,
        CMD_INV    = 4'd6,
        CMD_NEG    = 4'd7,
        CMD_INC    = 4'd8,
        CMD_DEC    = 4'd9,
        CMD_EQUAL  = 4'd10
    } cmd_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,     // latch item, start reduction of a
        OP_RED_B,    // start reduction of b
        OP_SIMPLE,   // simple commands into result
        OP_MUL,      // start modmul with selected operands
        OP_EUC_INIT, // set up euclid with selected value
        OP_EUC_DIV,  // start division x / y
        OP_EUC_UPD,  // apply quotient
        OP_INV_FIX,  // fold u into 0..m-1
        OP_POW_INIT,
        OP_POW_STEP  // shift exponent
    } op_t;

    typedef enum logic [1:0] {
        MS_ACC_BASE,  // acc * base
        MS_BASE_BASE, // base * base
        MS_A_T,       // a * t
        MS_A_B        // a * b
    } msel_t;

    typedef struct packed {
        op_t   op;
        msel_t msel;
        logic  euc_b; // b residue lands this cycle
        logic  mul_to_acc;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;   // divider running
        logic y_zero;
        logic e_zero;
        logic e_bit;
        logic gcd_one;
    } dp_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RED_A, ST_RED_B, ST_DISPATCH, ST_MUL_WAIT, ST_EUC_TEST,
        ST_EUC_WAIT, ST_EUC_DONE, ST_DIV_MUL, ST_MUL_START, ST_POW_TEST,
        ST_POW_SQ, ST_DONE
    } state_t;

endpackage

>>> rtl/core/mau_divider.sv
// ----------------------------------------------------------------------------
// mau_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mau_divider #(
    parameter int N = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [N-1:0] divisor,
    output logic         busy,
    output logic [N-1:0] quotient,
    output logic [N-1:0] remainder
);
    localparam int CW = $clog2(N + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [N-1:0]  q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [N:0]    trial;

    assign trial = {r_reg, q_reg[N-1]} - {1'b0, d_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        if (start)
        begin
            cnt_next = CW'(N);
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!trial[N])
            begin
                r_next = trial[N-1:0];
                q_next = {q_reg[N-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[N-2:0], q_reg[N-1]};
                q_next = {q_reg[N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule

>>> rtl/core/mau_datapath.sv
// ----------------------------------------------------------------------------
// mau_datapath
// Operand registers, shared divider, multiplier and euclid registers.
// ----------------------------------------------------------------------------
module mau_datapath
    import mau_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    input  logic [3:0]       command,
    input  logic [WIDTH-1:0] operand_a,
    input  logic [WIDTH-1:0] operand_b,
    input  logic [RES_W-1:0] exponent,
    input  logic [RES_W-1:0] modulus,
    output dp_stat_t         stat,
    output logic [RES_W-1:0] result,
    output logic             no_inverse
);
    localparam int DW = (2 * RES_W > WIDTH) ? 2 * RES_W : WIDTH;
    localparam int SW = RES_W + 2; // signed euclid coefficient width

    logic [RES_W-1:0] m_reg, a_reg, b_reg, acc_reg, base_reg, t_reg;
    logic [RES_W-1:0] e_reg, res_reg, x_reg, y_reg;
    logic [WIDTH-1:0] rawb_reg;
    logic [3:0]       code_reg;
    logic             nega_reg, negb_reg, flag_reg;
    logic [SW-1:0]    u_reg, v_reg;
    logic [2*RES_W-1:0] prod_reg;

    // shared divider
    logic          dv_start, dv_busy;
    logic [DW-1:0] dv_n, dv_d, dv_q, dv_r;
    logic [RES_W-1:0] rem, fixed;
    logic [RES_W-1:0] mx, my;
    logic [RES_W-1:0] m_eff;
    logic [WIDTH-1:0] mag_a, mag_b;
    logic [SW-1:0]    qv, u_mod;

    assign m_eff = (modulus == '0) ? RES_W'(1) : modulus;
    assign mag_a = operand_a[WIDTH-1] ? (~operand_a + 1'b1) : operand_a;
    assign mag_b = rawb_reg[WIDTH-1] ? (~rawb_reg + 1'b1) : rawb_reg;

    mau_divider #(.N(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_n),
        .divisor(dv_d), .busy(dv_busy), .quotient(dv_q), .remainder(dv_r)
    );

    assign rem = dv_r[RES_W-1:0];

    always_comb
    begin
        case (cmd.msel)
            MS_ACC_BASE:  begin mx = acc_reg;  my = base_reg; end
            MS_BASE_BASE: begin mx = base_reg; my = base_reg; end
            MS_A_T:       begin mx = a_reg;    my = t_reg;    end
            default:      begin mx = a_reg;    my = b_reg;    end
        endcase
    end

    always_comb
    begin
        dv_start = 1'b0;
        dv_n     = '0;
        dv_d     = DW'(m_reg);
        case (cmd.op)
            OP_LOAD:
            begin
                dv_start = 1'b1;
                dv_n     = DW'(mag_a);
                dv_d     = DW'(m_eff);
            end
            OP_RED_B:
            begin
                dv_start = 1'b1;
                dv_n     = DW'(mag_b);
            end
            OP_MUL:
            begin
                dv_start = 1'b1;
                dv_n     = DW'(prod_reg);
            end
            OP_EUC_DIV:
            begin
                dv_start = 1'b1;
                dv_n     = DW'(x_reg);
                dv_d     = DW'(y_reg);
            end
            default: ;
        endcase
    end

    // fold remainder of a negative operand
    function automatic logic [RES_W-1:0] wrap(input logic [RES_W-1:0] r,
                                              input logic neg,
                                              input logic [RES_W-1:0] m);
        return (neg && r != '0) ? m - r : r;
    endfunction

    // low bits of q * v are the same for signed and unsigned operands
    assign qv      = dv_q[SW-1:0] * v_reg;
    assign u_mod   = u_reg[SW-1] ? u_reg + SW'(m_reg) : u_reg;
    assign fixed   = u_mod[RES_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg  <= '0;
            flag_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_SIMPLE)
            begin
                flag_reg <= 1'b0;
                case (cmd_t'(code_reg))
                    CMD_REDUCE: res_reg <= a_reg;
                    CMD_ADD:
                    begin
                        if ({1'b0, a_reg} + {1'b0, b_reg} >= {1'b0, m_reg})
                            res_reg <= a_reg + b_reg - m_reg;
                        else
                            res_reg <= a_reg + b_reg;
                    end
                    CMD_SUB:   res_reg <= (a_reg >= b_reg) ? a_reg - b_reg
                                                           : a_reg + m_reg - b_reg;
                    CMD_NEG:   res_reg <= (a_reg == '0) ? '0 : m_reg - a_reg;
                    CMD_INC:   res_reg <= (a_reg + 1'b1 == m_reg) ? '0 : a_reg + 1'b1;
                    CMD_DEC:   res_reg <= (a_reg == '0) ? m_reg - 1'b1 : a_reg - 1'b1;
                    CMD_EQUAL: res_reg <= (a_reg == b_reg) ? RES_W'(1) : '0;
                    default:   res_reg <= '0;
                endcase
            end
            else if (cmd.op == OP_EUC_INIT || cmd.op == OP_LOAD)
                flag_reg <= 1'b0;
            else if (cmd.op == OP_INV_FIX)
            begin
                flag_reg <= !stat.gcd_one;
                res_reg  <= stat.gcd_one ? fixed : '0;
            end
            else if (cmd.op == OP_POW_INIT || cmd.op == OP_MUL)
                res_reg <= acc_reg;
            if (cmd.mul_to_acc && !dv_busy && cmd.op == OP_NONE)
                res_reg <= rem;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mx * my;
        case (cmd.op)
            OP_LOAD:
            begin
                m_reg    <= m_eff;
                nega_reg <= operand_a[WIDTH-1];
                negb_reg <= operand_b[WIDTH-1];
                rawb_reg <= operand_b;
                e_reg    <= exponent;
                code_reg <= command;
            end
            OP_RED_B: a_reg <= wrap(rem, nega_reg, m_reg);
            OP_SIMPLE: ;
            OP_EUC_INIT:
            begin
                x_reg <= cmd.euc_b ? wrap(rem, negb_reg, m_reg) : a_reg;
                y_reg <= m_reg;
                u_reg <= SW'(1);
                v_reg <= '0;
            end
            OP_EUC_UPD:
            begin
                x_reg <= y_reg;
                y_reg <= rem;
                u_reg <= v_reg;
                v_reg <= u_reg - qv;
            end
            OP_INV_FIX: t_reg <= fixed;
            OP_POW_INIT:
            begin
                acc_reg  <= (m_reg == RES_W'(1)) ? '0 : RES_W'(1);
                base_reg <= a_reg;
            end
            OP_POW_STEP: e_reg <= e_reg >> 1;
            default: ;
        endcase
        // multiplier results land when the divider finishes
        if (cmd.op == OP_NONE && !dv_busy && cmd.mul_to_acc)
        begin
            case (cmd.msel)
                MS_ACC_BASE:  acc_reg  <= rem;
                MS_BASE_BASE: base_reg <= rem;
                default: ;
            endcase
        end
        if (cmd.euc_b)
            b_reg <= wrap(rem, negb_reg, m_reg);
    end

    assign stat.busy    = dv_busy;
    assign stat.y_zero  = (y_reg == '0);
    assign stat.e_zero  = (e_reg == '0);
    assign stat.e_bit   = e_reg[0];
    assign stat.gcd_one = (x_reg == RES_W'(1)) || (m_reg == RES_W'(1));

    assign result     = res_reg;
    assign no_inverse = flag_reg;
endmodule

>>> rtl/core/mau_controller.sv
// ----------------------------------------------------------------------------
// mau_controller
// Sequencer of reduction, multiply, power and euclid steps.
// ----------------------------------------------------------------------------
module mau_controller
    import mau_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [3:0] command,
    input  logic       out_free,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd,
    output logic       idle,
    output logic       done
);
    state_t     state_reg, state_next;
    logic [3:0] cmd_reg, cmd_next;
    logic [1:0] ret_reg, ret_next; // what to do after a multiply
    msel_t      ms_reg, ms_next;

    localparam logic [1:0] RET_OUT = 2'd0, RET_ACC = 2'd1, RET_BASE = 2'd2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= '0;
            ret_reg   <= RET_OUT;
            ms_reg    <= MS_A_B;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            ret_reg   <= ret_next;
            ms_reg    <= ms_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        ret_next       = ret_reg;
        ms_next        = ms_reg;
        cmd.op         = OP_NONE;
        cmd.msel       = ms_reg;
        cmd.euc_b      = 1'b0;
        cmd.mul_to_acc = 1'b0;
        idle           = 1'b0;
        done           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (in_fire)
                begin
                    cmd.op     = OP_LOAD;
                    cmd_next   = command;
                    state_next = ST_RED_A;
                end
            end
            ST_RED_A:
                if (!stat.busy)
                begin
                    cmd.op     = OP_RED_B;
                    state_next = ST_RED_B;
                end
            ST_RED_B:
                if (!stat.busy)
                begin
                    // b residue lands here, ahead of the dispatch
                    state_next = ST_DISPATCH;
                    cmd.euc_b  = 1'b1;
                    if (cmd_t'(cmd_reg) == CMD_DIV)
                        cmd.op = OP_EUC_INIT;
                end
            ST_DISPATCH:
            begin
                case (cmd_t'(cmd_reg))
                    CMD_MUL:
                    begin
                        ms_next    = MS_A_B;
                        cmd.msel   = MS_A_B;
                        ret_next   = RET_OUT;
                        state_next = ST_DIV_MUL;
                    end
                    CMD_DIV, CMD_INV:
                    begin
                        if (cmd_t'(cmd_reg) == CMD_INV)
                            cmd.op = OP_EUC_INIT;
                        state_next = ST_EUC_TEST;
                    end
                    CMD_POW:
                    begin
                        cmd.op     = OP_POW_INIT;
                        state_next = ST_POW_TEST;
                    end
                    default:
                    begin
                        cmd.op     = OP_SIMPLE;
                        state_next = ST_DONE;
                    end
                endcase
            end
            // product register loads here from the selected operands
            ST_DIV_MUL:
                state_next = ST_MUL_START;
            ST_MUL_START:
            begin
                cmd.op     = OP_MUL;
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
                if (!stat.busy)
                begin
                    cmd.mul_to_acc = 1'b1;
                    if (ret_reg == RET_OUT)
                    begin
                        cmd.msel   = MS_A_B;
                        state_next = ST_DONE;
                    end
                    else if (ret_reg == RET_ACC)
                    begin
                        cmd.msel   = MS_ACC_BASE;
                        ms_next    = MS_BASE_BASE;
                        ret_next   = RET_BASE;
                        state_next = ST_DIV_MUL;
                    end
                    else
                    begin
                        cmd.msel   = MS_BASE_BASE;
                        cmd.op     = OP_NONE;
                        state_next = ST_POW_SQ;
                    end
                end
            ST_EUC_TEST:
                if (stat.y_zero)
                begin
                    cmd.op     = OP_INV_FIX;
                    state_next = ST_EUC_DONE;
                end
                else
                begin
                    cmd.op     = OP_EUC_DIV;
                    state_next = ST_EUC_WAIT;
                end
            ST_EUC_WAIT:
                if (!stat.busy)
                begin
                    cmd.op     = OP_EUC_UPD;
                    state_next = ST_EUC_TEST;
                end
            ST_EUC_DONE:
            begin
                if (cmd_t'(cmd_reg) == CMD_DIV && stat.gcd_one)
                begin
                    ms_next    = MS_A_T;
                    ret_next   = RET_OUT;
                    state_next = ST_DIV_MUL;
                end
                else
                    state_next = ST_DONE;
            end
            ST_POW_SQ:
            begin
                cmd.op     = OP_POW_STEP;
                state_next = ST_POW_TEST;
            end
            ST_POW_TEST:
            begin
                if (stat.e_zero)
                begin
                    cmd.op     = OP_MUL; // copies acc into result
                    cmd.msel   = MS_ACC_BASE;
                    state_next = ST_DONE;
                end
                else if (stat.e_bit)
                begin
                    ms_next    = MS_ACC_BASE;
                    ret_next   = RET_ACC;
                    state_next = ST_DIV_MUL;
                end
                else
                begin
                    ms_next    = MS_BASE_BASE;
                    ret_next   = RET_BASE;
                    state_next = ST_DIV_MUL;
                end
            end
            ST_DONE:
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == ST_DONE)
        else $error("done outside final state");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> state_reg == ST_IDLE)
        else $error("item taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EUC_WAIT && stat.busy) |=> state_reg == ST_EUC_WAIT)
        else $error("euclid left before division finished");
endmodule

>>> rtl/core/modular_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Modular ALU: reduce, add, sub, mul, div, pow, inv, neg, inc, dec, equal.
// ----------------------------------------------------------------------------
// operations: operand reduction is two divider passes; mul then runs one multiply,
//   pow up to 62 multiplies, inv/div one divider pass per euclid step (about 45
//   steps at most), div one multiply more
// flow: one item at a time, a new item is taken only while the unit is idle
// all passes run on the shared restoring divider, one bit a cycle over 62 bits
// reset: control returns to idle, output empty, modulus reads as 1
module modular_arithmetic_unit
    import mau_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [RES_W-1:0] cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    // command[3:0], operand_a, operand_b, exponent[30:0], zero pad
    input  logic [((4 + 2 * WIDTH + RES_W + 7) / 8) * 8 - 1:0] s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // result[30:0], no_inverse
    output logic [31:0]      m_tdata
);
    localparam int AL = 4;
    localparam int BL = 4 + WIDTH;
    localparam int EL = 4 + 2 * WIDTH;

    logic [RES_W-1:0] mod_reg;
    logic             ov_reg;
    logic [RES_W-1:0] ores_reg, dres;
    logic             oflag_reg, dflag;
    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic             idle, done, in_fire;

    assign cfg_ready = 1'b1;
    assign s_tready  = idle;
    assign in_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_reg <= RES_W'(1);
        else if (cfg_valid)
            mod_reg <= cfg_data;
    end

    mau_controller u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .command(s_tdata[3:0]),
        .out_free(!ov_reg || m_tready), .stat(stat), .cmd(cmd), .idle(idle),
        .done(done)
    );

    mau_datapath #(.WIDTH(WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .command(s_tdata[3:0]),
        .operand_a(s_tdata[AL +: WIDTH]), .operand_b(s_tdata[BL +: WIDTH]),
        .exponent(s_tdata[EL +: RES_W]), .modulus(mod_reg), .stat(stat),
        .result(dres), .no_inverse(dflag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (done)
            ov_reg <= 1'b1;
        else if (m_tready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            ores_reg  <= dres;
            oflag_reg <= dflag;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {oflag_reg, ores_reg};
endmodule

>>> verif/modular_arithmetic_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_test
// Self-checking bench for the modular ALU. Items go in on the input stream,
// results are checked in order against a predictor kept in the bench, across
// several modulus settings, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_test;
    import mau_pkg::*;

    localparam int WIDTH = 32;
    localparam int DW = ((4 + 2 * WIDTH + RES_W + 7) / 8) * 8;
    localparam longint CYCLE_LIMIT = 8000000;
    localparam logic [30:0] MOD_MAX = 31'h7fffffff;

    typedef struct packed {
        logic [30:0] residue;
        logic        no_inv;
    } outcome_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [RES_W-1:0] cfg_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [DW-1:0]    s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [31:0]      m_tdata;

    outcome_t    pending_q[$];
    logic [30:0] cur_modulus;
    bit          idle_on;
    int          hold_cycles;
    int          errors;
    int          n_items;
    int          n_results;
    longint      cycles;

    modular_arithmetic_unit #(.WIDTH(WIDTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic longint unsigned to_residue(logic [31:0] raw, longint unsigned m);
        longint unsigned mag;
        longint unsigned r;
        if (raw[31])
        begin
            mag = {32'd0, ~raw} + 64'd1;
            r = mag % m;
            return (r == 0) ? 0 : m - r;
        end
        return {32'd0, raw} % m;
    endfunction

    function automatic bit euclid_inverse(longint unsigned a, longint unsigned m,
                                          output longint unsigned inv);
        longint x;
        longint y;
        longint u;
        longint v;
        longint q;
        longint t;
        x = a;
        y = m;
        u = 1;
        v = 0;
        while (y > 0)
        begin
            q = x / y;
            t = x - q * y; x = y; y = t;
            t = u - q * v; u = v; v = t;
        end
        inv = 0;
        if (x != 1)
            return 0;
        t = u % longint'(m);
        if (t < 0)
            t += m;
        inv = t;
        return 1;
    endfunction

    function automatic outcome_t modular_outcome(logic [3:0] cmd, logic [31:0] op_a,
                                                 logic [31:0] op_b, logic [30:0] expo);
        longint unsigned m;
        longint unsigned a;
        longint unsigned b;
        longint unsigned r;
        longint unsigned t;
        longint unsigned base;
        outcome_t o;
        m = (cur_modulus == 0) ? 1 : cur_modulus;
        a = to_residue(op_a, m);
        b = to_residue(op_b, m);
        r = 0;
        o.no_inv = 1'b0;
        case (cmd)
            CMD_REDUCE: r = a;
            CMD_ADD:    r = (a + b) % m;
            CMD_SUB:    r = (a >= b) ? a - b : a + m - b;
            CMD_MUL:    r = (a * b) % m;
            CMD_DIV:
                if (euclid_inverse(b, m, t))
                    r = (a * t) % m;
                else
                    o.no_inv = 1'b1;
            CMD_POW:
            begin
                r = 1 % m;
                base = a;
                for (int i = 0; i < 31; i++)
                begin
                    if (expo[i])
                        r = (r * base) % m;
                    base = (base * base) % m;
                end
            end
            CMD_INV:
                if (!euclid_inverse(a, m, r))
                begin
                    r = 0;
                    o.no_inv = 1'b1;
                end
            CMD_NEG:    r = (a == 0) ? 0 : m - a;
            CMD_INC:    r = (a + 1) % m;
            CMD_DEC:    r = (a == 0) ? m - 1 : a - 1;
            CMD_EQUAL:  r = (a == b) ? 1 : 0;
            default:    r = 0;
        endcase
        o.residue = r[30:0];
        return o;
    endfunction

    // ------------------------------------------------------------------
    // result side: stall control and checking
    // ------------------------------------------------------------------
    initial
    begin
        int  stall;
        bit  rdy;
        stall = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                stall = idle_on ? $urandom_range(0, 11) : 0;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rdy = 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                rdy = 1'b0;
            end
            else
                rdy = rst_n;
            m_tready <= rdy;
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        outcome_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[30:0], m_tdata[31]};
            n_results++;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result transfer, actual result=%0d no_inverse=%0b",
                         $time, got.residue, got.no_inv);
                errors++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (got.residue !== want.residue)
                begin
                    $display("%0t: result mismatch, expected %0d actual %0d",
                             $time, want.residue, got.residue);
                    errors++;
                end
                if (got.no_inv !== want.no_inv)
                begin
                    $display("%0t: no_inverse mismatch, expected %0b actual %0b",
                             $time, want.no_inv, got.no_inv);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_item(logic [3:0] cmd, logic [31:0] op_a, logic [31:0] op_b,
                             logic [30:0] expo);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(DW - 99){1'b0}}, expo, op_b, op_a, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        pending_q.push_back(modular_outcome(cmd, op_a, op_b, expo));
        n_items++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_modulus(logic [30:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_modulus = value;
    endtask

    function automatic logic [3:0] random_cmd;
        if ($urandom_range(0, 9) == 0)
            return 4'($urandom_range(11, 15));
        return 4'($urandom_range(CMD_REDUCE, CMD_EQUAL));
    endfunction

    function automatic logic [31:0] random_operand;
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 40) - 20;
            1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'd0};
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_modulus;
        // modulus one after reset: every result is zero but equal's one, inverse of zero exists
        for (int c = CMD_REDUCE; c <= CMD_EQUAL; c++)
            send_item(4'(c), 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff);
    endtask

    task automatic test_directed_prime;
        logic [3:0] c;
        write_modulus(MOD_MAX);
        for (int i = CMD_REDUCE; i <= CMD_EQUAL; i++)
        begin
            c = 4'(i);
            send_item(c, 32'h8000_0000, 32'hffff_ffff, 31'h7fff_ffff);
        end
        send_item(CMD_DIV, 32'd5, 32'h7fff_ffff, 31'd0);    // divisor reduces to zero
        send_item(CMD_INV, 32'd0, 32'd0, 31'd0);
        send_item(CMD_POW, 32'd3, 32'd0, 31'd0);            // zero exponent
        send_item(CMD_EQUAL, 32'hffff_ffff, 32'h7fff_fffe, 31'd0);
        send_item(CMD_DEC, 32'd0, 32'd0, 31'd0);
        send_item(CMD_NEG, 32'd0, 32'd0, 31'd0);
        send_item(4'd15, 32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
    endtask

    task automatic test_composite;
        write_modulus(31'd12);
        send_item(CMD_INV, 32'd4, 32'd0, 31'd0);            // shares a factor
        send_item(CMD_INV, 32'd7, 32'd0, 31'd0);
        send_item(CMD_DIV, 32'd5, 32'hffff_fffa, 31'd0);
        send_item(CMD_DIV, 32'd5, 32'hffff_fff9, 31'd0);
        write_modulus(31'd0);                               // treated as one
        send_item(CMD_POW, 32'd9, 32'd0, 31'd0);
        send_item(CMD_INV, 32'd9, 32'd0, 31'd0);
        send_item(CMD_DEC, 32'd9, 32'd0, 31'd0);
    endtask

    task automatic test_random(logic [30:0] modulus_value, int count);
        write_modulus(modulus_value);
        for (int i = 0; i < count; i++)
        begin
            if (i % 20 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            send_item(random_cmd(), random_operand(), random_operand(),
                      31'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 40)));
        end
    endtask

    task automatic test_output_hold;
        // receiver holds off while items keep coming, input must stall
        write_modulus(31'd1000003);
        hold_cycles = 12000;
        for (int i = 0; i < 6; i++)
            send_item(random_cmd(), $urandom, $urandom, 31'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cur_modulus = 31'd1;
        idle_on = 1'b1;
        hold_cycles = 0;
        errors = 0;
        n_items = 0;
        n_results = 0;
        cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_modulus();
        test_directed_prime();
        test_composite();
        test_output_hold();
        test_random(31'd2, 20);
        test_random(31'd97, 50);
        test_random(31'd360, 50);
        test_random(MOD_MAX, 60);
        test_random(31'($urandom_range(2, 1000)), 40);
        test_random(31'($urandom | 32'h4000_0000), 40);
        drain();

        $display("covered %0d items, %0d results, moduli 0, 1, 2, small, composite and 2^31-1",
                 n_items, n_results);
        $display("all commands including unused codes, missing inverses and output backpressure");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/mau_pkg.sv
rtl/core/mau_divider.sv
rtl/core/mau_datapath.sv
rtl/core/mau_controller.sv
rtl/core/modular_arithmetic_unit.sv
verif/modular_arithmetic_unit_test.sv
